// ===== hw/rtl/deadlock_detection_check_assert.svh =====
// assertion macros for the deadlock detection check
// expects clk and arst_n in the scope where a macro is used
`ifndef DEADLOCK_DETECTION_CHECK_ASSERT_SVH
`define DEADLOCK_DETECTION_CHECK_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DLC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DLC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/dlc_pkg.sv =====
// shared constants for the deadlock detection check
// no dependencies
package dlc_pkg;

	localparam int NUM_PROCS_DEF = 4;
	localparam int NUM_RES_DEF   = 4;
	localparam int UNIT_BITS_DEF = 8;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 2;
	localparam int VALUE_W = 8;
	localparam int MASK_W  = 4;
	localparam int TOTAL_W = 64;

	localparam logic [OP_W-1:0] OP_WR_ALLOC = 2'd0;
	localparam logic [OP_W-1:0] OP_WR_REQ   = 2'd1;
	localparam logic [OP_W-1:0] OP_CHECK    = 2'd2;

endpackage

// ===== hw/rtl/dlc_in_if.sv =====
// input word channel: entry writes and check requests
// depends on dlc_pkg
interface dlc_in_if;
	logic                         valid;
	logic                         ready;
	logic [dlc_pkg::OP_W-1:0]     operation;
	logic [dlc_pkg::IDX_W-1:0]    proc_index;
	logic [dlc_pkg::IDX_W-1:0]    res_index;
	logic [dlc_pkg::VALUE_W-1:0]  entry_value;

	modport source (output valid, operation, proc_index, res_index, entry_value, input ready);
	modport sink (input valid, operation, proc_index, res_index, entry_value, output ready);
endinterface

// ===== hw/rtl/dlc_out_if.sv =====
// result word channel: outcome of one check
// depends on dlc_pkg
interface dlc_out_if;
	logic                        valid;
	logic                        ready;
	logic                        over_allocated;
	logic                        deadlock_free;
	logic [dlc_pkg::MASK_W-1:0]  finished_mask;

	modport source (output valid, over_allocated, deadlock_free, finished_mask, input ready);
	modport sink (input valid, over_allocated, deadlock_free, finished_mask, output ready);
endinterface

// ===== hw/rtl/deadlock_detection_check.sv =====
// deadlock detection check: allocation/request stores and the check sequencer
// depends on dlc_pkg, dlc_in_if, dlc_out_if, deadlock_detection_check_assert.svh
//
// channel   dir   handshake      word
// item      in    valid/ready    operation, proc_index, res_index, entry_value
// result    out   valid/ready    over_allocated, deadlock_free, finished_mask
// cfg       in    cfg_we         cfg_data (total units, packed per resource)
//
// an entry write is stored when it is accepted; a new word is taken every cycle while idle
// a check walks both row memories one process a cycle: a summing pass over the
// allocations, then NUM_PROCS passes over the requests, skipped when over-allocated
// item.ready is low during a check; a result not yet taken holds the next check
// reset clears both stores at once through per-row valid bits, no clearing pass
`include "deadlock_detection_check_assert.svh"

module deadlock_detection_check #(
	parameter int NUM_PROCS = dlc_pkg::NUM_PROCS_DEF,
	parameter int NUM_RES   = dlc_pkg::NUM_RES_DEF,
	parameter int UNIT_BITS = dlc_pkg::UNIT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [dlc_pkg::TOTAL_W-1:0]   cfg_data,
	dlc_in_if.sink                        item,
	dlc_out_if.source                     result
);

	localparam int PW    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int ROW_W = NUM_RES * UNIT_BITS;
	localparam int AW    = UNIT_BITS + PW + 2;
	localparam int FW    = NUM_PROCS + dlc_pkg::MASK_W;
	localparam logic [PW-1:0] LAST_P = PW'(NUM_PROCS - 1);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_SUM      = 3'd1;
	localparam logic [2:0] ST_SUM_WAIT = 3'd2;
	localparam logic [2:0] ST_EVAL     = 3'd3;
	localparam logic [2:0] ST_RUN      = 3'd4;
	localparam logic [2:0] ST_RUN_WAIT = 3'd5;
	localparam logic [2:0] ST_DONE     = 3'd6;

	logic [2:0]                    state_q;
	logic [PW-1:0]                 cnt_q;
	logic [PW-1:0]                 pass_q;
	logic [dlc_pkg::TOTAL_W-1:0]   total_q;

	logic [ROW_W-1:0]              alloc_mem [NUM_PROCS];
	logic [ROW_W-1:0]              req_mem [NUM_PROCS];
	logic [NUM_PROCS-1:0]          alloc_vld_q;
	logic [NUM_PROCS-1:0]          req_vld_q;
	logic [ROW_W-1:0]              alloc_rd_s1;
	logic [ROW_W-1:0]              req_rd_s1;
	logic                          rdv_s1;
	logic [PW-1:0]                 rdp_s1;

	logic signed [AW-1:0]          avail_q [NUM_RES];
	logic [NUM_PROCS-1:0]          fin_q;
	logic                          over_q;

	logic                          out_v_q;
	logic                          out_over_q;
	logic                          out_free_q;
	logic [dlc_pkg::MASK_W-1:0]    out_mask_q;

	logic                          item_acc;
	logic                          is_check;
	logic                          wr_ok;
	logic                          alloc_we;
	logic                          req_we;
	logic [PW-1:0]                 wr_addr;
	logic [NUM_RES-1:0]            wsel;
	logic [UNIT_BITS-1:0]          wval;
	logic [UNIT_BITS-1:0]          tot [NUM_RES];
	logic [UNIT_BITS-1:0]          tot_sel;
	logic                          rd_en;
	logic                          sum_ph;
	logic                          run_ph;
	logic [ROW_W-1:0]              arow;
	logic [ROW_W-1:0]              rrow;
	logic                          fits;
	logic                          row_idle;
	logic                          take;
	logic                          avail_neg;
	logic                          out_load;
	logic [FW-1:0]                 fin_ext;

	assign item.ready = (state_q == ST_IDLE);
	assign item_acc   = item.valid && item.ready;
	assign is_check   = (item.operation == dlc_pkg::OP_CHECK);
	assign wr_addr    = PW'(item.proc_index);
	assign wval       = UNIT_BITS'(item.entry_value);

	always_comb begin
		tot_sel = '0;
		for (int j = 0; j < NUM_RES; j++) begin
			tot[j]  = total_q[j*UNIT_BITS +: UNIT_BITS];
			wsel[j] = (int'(item.res_index) == j);
			if (wsel[j]) tot_sel = tot[j];
		end
	end

	// out-of-range indexes and values too wide for a unit are dropped, as are allocations above the total
	assign wr_ok = item_acc
		&& ((item.operation == dlc_pkg::OP_WR_ALLOC) || (item.operation == dlc_pkg::OP_WR_REQ))
		&& (int'(item.proc_index) < NUM_PROCS) && (int'(item.res_index) < NUM_RES)
		&& ((item.entry_value >> UNIT_BITS) == '0);
	assign alloc_we = wr_ok && (item.operation == dlc_pkg::OP_WR_ALLOC) && (wval <= tot_sel);
	assign req_we   = wr_ok && (item.operation == dlc_pkg::OP_WR_REQ);

	assign rd_en  = (state_q == ST_SUM) || (state_q == ST_RUN);
	assign sum_ph = (state_q == ST_SUM) || (state_q == ST_SUM_WAIT);
	assign run_ph = (state_q == ST_RUN) || (state_q == ST_RUN_WAIT);

	// a row written into an invalid slot gets zeros in every other entry
	always_ff @(posedge clk) begin
		for (int j = 0; j < NUM_RES; j++) begin
			if (alloc_we && wsel[j])
				alloc_mem[wr_addr][j*UNIT_BITS +: UNIT_BITS] <= wval;
			else if (alloc_we && !alloc_vld_q[wr_addr])
				alloc_mem[wr_addr][j*UNIT_BITS +: UNIT_BITS] <= '0;
			if (req_we && wsel[j])
				req_mem[wr_addr][j*UNIT_BITS +: UNIT_BITS] <= wval;
			else if (req_we && !req_vld_q[wr_addr])
				req_mem[wr_addr][j*UNIT_BITS +: UNIT_BITS] <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			alloc_rd_s1 <= alloc_mem[cnt_q];
			req_rd_s1   <= req_mem[cnt_q];
		end
	end

	// valid bits are looked at when the data is used, so a clear from the
	// previous process is already seen
	always_comb begin
		arow     = alloc_vld_q[rdp_s1] ? alloc_rd_s1 : '0;
		rrow     = req_vld_q[rdp_s1] ? req_rd_s1 : '0;
		row_idle = (arow == '0) && (rrow == '0);
		fits     = 1'b1;
		avail_neg = 1'b0;
		for (int j = 0; j < NUM_RES; j++) begin
			if (avail_q[j] < $signed(AW'(rrow[j*UNIT_BITS +: UNIT_BITS]))) fits = 1'b0;
			if (avail_q[j][AW-1]) avail_neg = 1'b1;
		end
		take = fits && !row_idle && !fin_q[rdp_s1];
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < NUM_RES; j++) begin
			if (item_acc && is_check)
				avail_q[j] <= $signed(AW'(tot[j]));
			else if (rdv_s1 && sum_ph)
				avail_q[j] <= avail_q[j] - $signed(AW'(arow[j*UNIT_BITS +: UNIT_BITS]));
			else if (rdv_s1 && run_ph && take)
				avail_q[j] <= avail_q[j] + $signed(AW'(arow[j*UNIT_BITS +: UNIT_BITS]));
		end
	end

	assign out_load = (state_q == ST_DONE) && (!out_v_q || result.ready);
	assign fin_ext  = FW'(fin_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			pass_q      <= '0;
			total_q     <= '0;
			alloc_vld_q <= '0;
			req_vld_q   <= '0;
			rdv_s1      <= 1'b0;
			rdp_s1      <= '0;
			fin_q       <= '0;
			over_q      <= 1'b0;
			out_v_q     <= 1'b0;
			out_over_q  <= 1'b0;
			out_free_q  <= 1'b0;
			out_mask_q  <= '0;
		end else begin
			if (cfg_we) total_q <= cfg_data;
			if (alloc_we) alloc_vld_q[wr_addr] <= 1'b1;
			if (req_we) req_vld_q[wr_addr] <= 1'b1;

			rdv_s1 <= rd_en;
			rdp_s1 <= cnt_q;

			if (rdv_s1 && run_ph) begin
				if (row_idle || take) fin_q[rdp_s1] <= 1'b1;
				if (take) begin
					alloc_vld_q[rdp_s1] <= 1'b0;
					req_vld_q[rdp_s1]   <= 1'b0;
				end
			end

			if (out_load) out_v_q <= 1'b1;
			else if (out_v_q && result.ready) out_v_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (item_acc && is_check) begin
						fin_q   <= '0;
						over_q  <= 1'b0;
						cnt_q   <= '0;
						state_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					if (cnt_q == LAST_P) begin
						cnt_q   <= '0;
						state_q <= ST_SUM_WAIT;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SUM_WAIT: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (avail_neg) begin
						over_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						cnt_q   <= '0;
						pass_q  <= '0;
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cnt_q == LAST_P) begin
						cnt_q <= '0;
						if (pass_q == LAST_P) state_q <= ST_RUN_WAIT;
						else pass_q <= pass_q + 1'b1;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_RUN_WAIT: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_over_q <= over_q;
						out_free_q <= !over_q && (&fin_q);
						out_mask_q <= over_q ? '0 : fin_ext[dlc_pkg::MASK_W-1:0];
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign result.valid          = out_v_q;
	assign result.over_allocated = out_over_q;
	assign result.deadlock_free  = out_free_q;
	assign result.finished_mask  = out_mask_q;

	`DLC_ASSERT_IMP(a_result_from_done, $rose(out_v_q), $past(state_q) == ST_DONE,
		"result raised outside done")
	`DLC_ASSERT_IMP(a_run_avail_nonneg, run_ph, !avail_neg,
		"available units negative during passes")
	`DLC_ASSERT_NXT(a_check_starts_sum, item_acc && is_check, state_q == ST_SUM,
		"check did not start summing")
	`DLC_ASSERT_IMP(a_over_clears_fields, out_v_q && out_over_q,
		!out_free_q && (out_mask_q == '0), "over-allocated result carries a mask")

endmodule
